>>> hdl/tcw_pkg.sv
package tcw_pkg;

    // Frame geometry limits and tab spacing (TAB_STOP must be a power of two).
    localparam int MAX_COLS    = 128;
    localparam int MAX_ROWS    = 64;
    localparam int TAB_STOP    = 8;
    localparam int TAB_SHIFT   = $clog2(TAB_STOP);
    localparam int STORE_CELLS = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_CELLS);
    localparam int CNT_W       = ADDR_W + 1;

    // Fixed field widths.
    localparam int FUNC_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 7;
    localparam int CELL_W     = 16;
    localparam int CFG_COLS_W = 8;
    localparam int CFG_ROWS_W = 7;
    localparam int ATTR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTRIBUTE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_ENABLE  = 2'd3;

    localparam logic [CFG_COLS_W-1:0] RESET_COLS   = 8'd80;
    localparam logic [CFG_ROWS_W-1:0] RESET_ROWS   = 7'd25;
    localparam logic [ATTR_W-1:0]     RESET_ATTR   = 8'h07;
    localparam logic                  RESET_SCROLL = 1'b1;

    // Control characters.
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

    // What a frame walk does to the store.
    typedef enum logic [1:0] {
        WALK_INIT   = 2'd0,
        WALK_BLANK  = 2'd1,
        WALK_SCROLL = 2'd2
    } walk_kind_t;

    typedef struct packed {
        logic       take_in;
        logic       exec;
        logic       walk_start;
        walk_kind_t walk_kind;
        logic       load_out;
        logic       load_exec;
    } tcw_cmd_t;

    typedef struct packed {
        logic is_read;
        logic is_clear;
        logic scroll;
        logic walk_busy;
        logic out_free;
    } tcw_sts_t;

endpackage

>>> hdl/tcw_ram.sv
module tcw_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 8192
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/tcw_ctrl.sv
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tcw_sts_t sts,
    output tcw_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_EXEC   = 5'b00100,
        ST_WALK   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        cmd.take_in    = 1'b0;
        cmd.exec       = 1'b0;
        cmd.walk_start = 1'b0;
        cmd.walk_kind  = WALK_BLANK;
        cmd.load_out   = 1'b0;
        cmd.load_exec  = 1'b0;
        case (state_reg)
            ST_INIT: begin
                if (!sts.walk_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.take_in = s_valid;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (sts.is_clear) begin
                    cmd.walk_start = 1'b1;
                    cmd.walk_kind  = WALK_BLANK;
                    state_next     = ST_WALK;
                end else if (sts.scroll) begin
                    cmd.walk_start = 1'b1;
                    cmd.walk_kind  = WALK_SCROLL;
                    state_next     = ST_WALK;
                end else if (sts.is_read) begin
                    state_next = ST_FINISH;
                end else if (sts.out_free) begin
                    cmd.load_out  = 1'b1;
                    cmd.load_exec = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_WALK: begin
                if (!sts.walk_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

>>> hdl/tcw_dp.sv
module tcw_dp
    import tcw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [FUNC_W-1:0]     s_func,
    input  logic [CHAR_W-1:0]     s_char_code,
    input  logic [ADDR_W-1:0]     s_cell_index,
    input  tcw_cmd_t              cmd,
    output tcw_sts_t              sts,
    input  logic                  m_ready,
    output logic                  m_valid,
    output logic [ROW_W-1:0]      m_cursor_row,
    output logic [COL_W-1:0]      m_cursor_col,
    output logic                  m_scrolled,
    output logic [CELL_W-1:0]     m_cell_data
);

    // Configuration registers.
    logic [CFG_COLS_W-1:0] cols_reg;
    logic [CFG_ROWS_W-1:0] rows_reg;
    logic [ATTR_W-1:0]     attr_reg;
    logic                  scroll_en_reg;
    logic [CFG_COLS_W-1:0] cols_eff;
    logic [CFG_ROWS_W-1:0] rows_eff;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic [CNT_W-1:0]      move_reg, move_next;

    // Latched item and cursor.
    logic [FUNC_W-1:0] func_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              scrolled_reg, scrolled_next;

    // Cursor arithmetic for a put.
    logic              is_put;
    logic [ROW_W-1:0]  row_c;
    logic [COL_W-1:0]  col_c;
    logic [ROW_W:0]    r1, r2;
    logic [COL_W:0]    c1, c2;
    logic              char_wr;
    logic              put_scroll;
    logic [ROW_W-1:0]  put_row;
    logic [COL_W-1:0]  put_col;
    logic [ADDR_W-1:0] char_addr;

    // Frame walk.
    logic              walk_busy_reg, walk_busy_next;
    walk_kind_t        walk_kind_reg, walk_kind_next;
    logic [CNT_W-1:0]  walk_cnt_reg, walk_cnt_next;
    logic [CNT_W-1:0]  walk_end;
    logic              walk_issue;
    logic              walk_src_mem;
    logic [ADDR_W-1:0] walk_rd_addr;
    logic              wr_pend_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic              wr_blank_reg;
    logic [CELL_W-1:0] fill_cell;

    // Memory ports.
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [CELL_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [CELL_W-1:0] ram_rd_data;

    // Output register.
    logic              m_valid_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic              out_scrolled_reg;
    logic [CELL_W-1:0] out_data_reg;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (cols_reg == '0) begin
            cols_eff = CFG_COLS_W'(1);
        end else if (cols_reg > CFG_COLS_W'(MAX_COLS)) begin
            cols_eff = CFG_COLS_W'(MAX_COLS);
        end else begin
            cols_eff = cols_reg;
        end
        if (rows_reg == '0) begin
            rows_eff = CFG_ROWS_W'(1);
        end else if (rows_reg > CFG_ROWS_W'(MAX_ROWS)) begin
            rows_eff = CFG_ROWS_W'(MAX_ROWS);
        end else begin
            rows_eff = rows_reg;
        end
    end

    assign total_next = CNT_W'(rows_eff) * CNT_W'(cols_eff);
    assign move_next  = CNT_W'(rows_eff - 1'b1) * CNT_W'(cols_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg      <= RESET_COLS;
            rows_reg      <= RESET_ROWS;
            attr_reg      <= RESET_ATTR;
            scroll_en_reg <= RESET_SCROLL;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SCREEN_COLS:    cols_reg      <= cfg_data;
                CFG_SCREEN_ROWS:    rows_reg      <= cfg_data[CFG_ROWS_W-1:0];
                CFG_TEXT_ATTRIBUTE: attr_reg      <= cfg_data;
                CFG_SCROLL_ENABLE:  scroll_en_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= total_next;
        move_reg  <= move_next;
        if (cmd.take_in) begin
            func_reg <= s_func;
            char_reg <= s_char_code;
            idx_reg  <= s_cell_index;
        end
    end

    // Put: clamp the cursor into the screen, step it, then wrap or scroll.
    assign is_put = (func_reg == FUNC_PUT);

    always_comb begin
        if ({1'b0, row_reg} >= rows_eff) begin
            row_c = ROW_W'(rows_eff - 1'b1);
        end else begin
            row_c = row_reg;
        end
        if ({1'b0, col_reg} >= cols_eff) begin
            col_c = COL_W'(cols_eff - 1'b1);
        end else begin
            col_c = col_reg;
        end

        char_wr = 1'b0;
        r1      = {1'b0, row_c};
        c1      = {1'b0, col_c};
        case (char_reg)
            CH_LF: begin
                r1 = {1'b0, row_c} + 1'b1;
                c1 = '0;
            end
            CH_VT, CH_FF: begin
                r1 = {1'b0, row_c} + 1'b1;
            end
            CH_CR: begin
                c1 = '0;
            end
            CH_TAB: begin
                c1 = ((({1'b0, col_c}) >> TAB_SHIFT) + 1'b1) << TAB_SHIFT;
            end
            default: begin
                char_wr = 1'b1;
                c1      = {1'b0, col_c} + 1'b1;
            end
        endcase

        if (c1 >= cols_eff) begin
            r2 = r1 + 1'b1;
            c2 = '0;
        end else begin
            r2 = r1;
            c2 = c1;
        end
        put_col    = c2[COL_W-1:0];
        put_scroll = 1'b0;
        if (r2 < rows_eff) begin
            put_row = r2[ROW_W-1:0];
        end else if (!scroll_en_reg) begin
            put_row = '0;
        end else begin
            put_row    = ROW_W'(rows_eff - 1'b1);
            put_scroll = 1'b1;
        end
    end

    assign char_addr = ADDR_W'(ADDR_W'(row_c) * ADDR_W'(cols_eff) + ADDR_W'(col_c));

    always_comb begin
        row_next      = row_reg;
        col_next      = col_reg;
        scrolled_next = 1'b0;
        case (func_reg)
            FUNC_PUT: begin
                row_next      = put_row;
                col_next      = put_col;
                scrolled_next = put_scroll;
            end
            FUNC_CLEAR: begin
                row_next = '0;
                col_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            scrolled_reg <= 1'b0;
        end else if (cmd.exec) begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            scrolled_reg <= scrolled_next;
        end
    end

    // Frame walk: one cell a cycle; a scroll reads one row ahead and writes
    // the cell in the following cycle, then blanks the bottom row.
    assign walk_end     = (walk_kind_reg == WALK_SCROLL) ? total_reg : CNT_W'(STORE_CELLS);
    assign walk_issue   = walk_busy_reg && (walk_cnt_reg < walk_end);
    assign walk_src_mem = (walk_kind_reg == WALK_SCROLL) && (walk_cnt_reg < move_reg);
    assign walk_rd_addr = ADDR_W'(walk_cnt_reg + CNT_W'(cols_eff));
    assign fill_cell    = (walk_kind_reg == WALK_INIT) ? RESET_CELL : {attr_reg, CH_SPACE};

    always_comb begin
        walk_busy_next = walk_busy_reg;
        walk_kind_next = walk_kind_reg;
        walk_cnt_next  = walk_cnt_reg;
        if (cmd.walk_start) begin
            walk_busy_next = 1'b1;
            walk_kind_next = cmd.walk_kind;
            walk_cnt_next  = '0;
        end else if (walk_busy_reg) begin
            if (walk_issue) begin
                walk_cnt_next = walk_cnt_reg + 1'b1;
            end else if (!wr_pend_reg) begin
                walk_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_busy_reg <= 1'b1;
            walk_kind_reg <= WALK_INIT;
            walk_cnt_reg  <= '0;
            wr_pend_reg   <= 1'b0;
        end else begin
            walk_busy_reg <= walk_busy_next;
            walk_kind_reg <= walk_kind_next;
            walk_cnt_reg  <= walk_cnt_next;
            wr_pend_reg   <= walk_issue;
        end
    end

    always_ff @(posedge aclk) begin
        wr_addr_reg  <= walk_cnt_reg[ADDR_W-1:0];
        wr_blank_reg <= !walk_src_mem;
    end

    always_comb begin
        ram_wr_en   = wr_pend_reg || (cmd.exec && is_put && char_wr);
        ram_wr_addr = wr_pend_reg ? wr_addr_reg : char_addr;
        if (wr_pend_reg) begin
            ram_wr_data = wr_blank_reg ? fill_cell : ram_rd_data;
        end else begin
            ram_wr_data = {attr_reg, char_reg};
        end
        ram_rd_en   = (walk_issue && walk_src_mem) || (cmd.exec && sts.is_read);
        ram_rd_addr = cmd.exec ? idx_reg : walk_rd_addr;
    end

    tcw_ram #(
        .DATA_W (CELL_W),
        .DEPTH  (STORE_CELLS)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Status towards the controller.
    assign sts.is_read   = (func_reg == FUNC_READ);
    assign sts.is_clear  = (func_reg == FUNC_CLEAR);
    assign sts.scroll    = is_put && put_scroll;
    assign sts.walk_busy = walk_busy_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (cmd.load_exec) begin
                out_row_reg      <= row_next;
                out_col_reg      <= col_next;
                out_scrolled_reg <= scrolled_next;
                out_data_reg     <= '0;
            end else begin
                out_row_reg      <= row_reg;
                out_col_reg      <= col_reg;
                out_scrolled_reg <= scrolled_reg;
                out_data_reg     <= sts.is_read ? ram_rd_data : '0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cursor_row = out_row_reg;
    assign m_cursor_col = out_col_reg;
    assign m_scrolled   = out_scrolled_reg;
    assign m_cell_data  = out_data_reg;

endmodule

>>> hdl/text_console_character_writer.sv
// Channel   Handshake              Word carried
// input     s_valid / s_ready      s_func, s_char_code, s_cell_index
// result    m_valid / m_ready      m_cursor_row, m_cursor_col, m_scrolled, m_cell_data
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A put that does not scroll is accepted and then executed; a read also passes through a finish step.
// A scroll walks rows*cols cells and a clear all 8192 cells, one cell a cycle
// through the single write port of the frame memory.
// After reset a pass blanks the frame memory; s_ready stays low until it ends.
// A result that waits in the output register holds back the next result, and
// the input once that next word has been taken.
module text_console_character_writer
    import tcw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [FUNC_W-1:0]     s_func,
    input  logic [CHAR_W-1:0]     s_char_code,
    input  logic [ADDR_W-1:0]     s_cell_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ROW_W-1:0]      m_cursor_row,
    output logic [COL_W-1:0]      m_cursor_col,
    output logic                  m_scrolled,
    output logic [CELL_W-1:0]     m_cell_data
);

    // The controller sequences each word: it accepts it, lets the datapath
    // execute it, starts a frame walk when the operation is a clear or a put
    // that scrolls past the bottom row, and finally hands the result to the
    // output register once that register is free.
    tcw_cmd_t cmd;
    tcw_sts_t sts;

    tcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds the configuration, the cursor, the frame memory with
    // its walk engine, and the output register.
    tcw_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_func       (s_func),
        .s_char_code  (s_char_code),
        .s_cell_index (s_cell_index),
        .cmd          (cmd),
        .sts          (sts),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_cursor_row (m_cursor_row),
        .m_cursor_col (m_cursor_col),
        .m_scrolled   (m_scrolled),
        .m_cell_data  (m_cell_data)
    );

endmodule
